>>> sv/sfit_pkg.sv
// Shared types and constants for the sorted free interval table.
`default_nettype none

package sfit_pkg;

   localparam int MAX_INTERVALS_DEF = 64;
   localparam int COORD_BITS_DEF    = 24;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_APPEND = 3'd1,
      OP_USE    = 3'd2,
      OP_QUERY  = 3'd3,
      OP_PRUNE  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ORDER     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_SAMPLE,
      ACT_APPEND,
      ACT_SHIFT_DOWN,
      ACT_TRIM_LEFT,
      ACT_TRIM_RIGHT,
      ACT_SPLIT
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_PRUNE,
      ST_HOLD
   } st_type;

   typedef struct packed {
      act_type act;
      logic    first;
      logic    above;
      logic    first_left;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> sv/sfit_cell.sv
// One table cell: holds one interval, compares it with a request and moves it along the row.
`default_nettype none

module sfit_cell #(
   parameter int INDEX         = 0,
   parameter int MAX_INTERVALS = sfit_pkg::MAX_INTERVALS_DEF,
   parameter int COORD_BITS    = sfit_pkg::COORD_BITS_DEF,
   localparam int CNT_BITS     = $clog2(MAX_INTERVALS + 1)
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire sfit_pkg::cell_ctl_type ctl,
   input  wire  [CNT_BITS-1:0]     count,
   input  wire  [COORD_BITS-1:0]   smp_lo,
   input  wire  [COORD_BITS:0]     smp_hi,
   input  wire  [COORD_BITS-1:0]   smp_width,
   input  wire  [COORD_BITS-1:0]   app_lo,
   input  wire  [COORD_BITS:0]     app_hi,
   input  wire  [COORD_BITS-1:0]   app_end,
   input  wire  [COORD_BITS-1:0]   left_start,
   input  wire  [COORD_BITS-1:0]   left_end,
   input  wire  [COORD_BITS-1:0]   right_start,
   input  wire  [COORD_BITS-1:0]   right_end,
   input  wire                     right_drop,
   output logic [COORD_BITS-1:0]   cell_start,
   output logic [COORD_BITS-1:0]   cell_end,
   output logic [COORD_BITS-1:0]   start_next,
   output logic                    hit,
   output logic                    lo_match,
   output logic                    hi_match,
   output logic                    last_below,
   output logic                    drop
);
   import sfit_pkg::*;

   localparam logic [CNT_BITS-1:0] IDX      = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] IDX_NEXT = CNT_BITS'(INDEX + 1);

   logic [COORD_BITS-1:0] start_ff, start_in;
   logic [COORD_BITS-1:0] end_ff, end_in;
   logic                  hit_ff, hit_in;
   logic                  loeq_ff, loeq_in;
   logic                  hieq_ff, hieq_in;
   logic                  lt_ff, lt_in;
   logic                  drop_ff, drop_in;
   logic                  valid;

   assign valid = IDX < count;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      hit_in   = hit_ff;
      loeq_in  = loeq_ff;
      hieq_in  = hieq_ff;
      lt_in    = lt_ff;
      drop_in  = drop_ff;
      unique case (ctl.act)
         ACT_NONE: begin
         end
         ACT_SAMPLE: begin
            hit_in  = valid && (start_ff <= smp_lo) && (smp_hi <= {1'b0, end_ff});
            loeq_in = start_ff == smp_lo;
            hieq_in = smp_hi == {1'b0, end_ff};
            lt_in   = smp_lo < end_ff;
            drop_in = valid && ((end_ff - start_ff) < smp_width);
         end
         ACT_APPEND: begin
            if (IDX == count) begin
               start_in = app_lo;
               end_in   = app_end;
            end
         end
         ACT_SHIFT_DOWN: begin
            if (ctl.first || ctl.above) begin
               start_in = right_start;
               end_in   = right_end;
               drop_in  = right_drop;
            end
         end
         ACT_TRIM_LEFT: begin
            if (ctl.first) begin
               start_in = app_hi[COORD_BITS-1:0];
            end
         end
         ACT_TRIM_RIGHT: begin
            if (ctl.first) begin
               end_in = app_lo;
            end
         end
         ACT_SPLIT: begin
            priority if (ctl.first) begin
               end_in = app_lo;
            end else if (ctl.first_left) begin
               start_in = app_hi[COORD_BITS-1:0];
               end_in   = left_end;
            end else if (ctl.above) begin
               start_in = left_start;
               end_in   = left_end;
            end else begin
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      if (reset) begin
         hit_ff  <= 1'b0;
         loeq_ff <= 1'b0;
         hieq_ff <= 1'b0;
         lt_ff   <= 1'b0;
         drop_ff <= 1'b0;
      end else begin
         hit_ff  <= hit_in;
         loeq_ff <= loeq_in;
         hieq_ff <= hieq_in;
         lt_ff   <= lt_in;
         drop_ff <= drop_in;
      end
   end

   assign cell_start = start_ff;
   assign cell_end   = end_ff;
   assign start_next = start_in;
   assign hit        = hit_ff;
   assign lo_match   = loeq_ff;
   assign hi_match   = hieq_ff;
   assign last_below = lt_ff && (IDX_NEXT == count);
   assign drop       = drop_ff;

endmodule

`default_nettype wire

>>> sv/sorted_free_interval_table.sv
// Top level of the sorted free interval table: request control and the row of cells.
// The table is a row of MAX_INTERVALS cells, each holding one half-open free interval,
// kept sorted from cell zero upward. One item is handled at a time. In the accept cycle
// every cell compares its interval with the request; in the next cycle the first matching
// cell and its neighbors update in one shift, and the result is registered once the output
// register is free. Prune removes one short interval per cycle by shifting the cells above
// it down until none is left. The table needs no initialization after reset. A new item can
// be accepted while the previous result still waits in the output register.
`default_nettype none

module sorted_free_interval_table #(
   parameter int MAX_INTERVALS = sfit_pkg::MAX_INTERVALS_DEF,
   parameter int COORD_BITS    = sfit_pkg::COORD_BITS_DEF,
   localparam int CNT_BITS     = $clog2(MAX_INTERVALS + 1)
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [2:0]            req_op,
   input  wire  [COORD_BITS-1:0] req_position,
   input  wire  [COORD_BITS-1:0] req_end_position,
   input  wire  [COORD_BITS-1:0] req_span_length,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [1:0]            rsp_status,
   output logic                  rsp_available,
   output logic [CNT_BITS-1:0]   rsp_interval_count,
   output logic [COORD_BITS-1:0] rsp_leftmost_start
);
   import sfit_pkg::*;

   localparam int N = MAX_INTERVALS;

   st_type                state_ff, state_in;
   op_type                op_ff;
   logic [COORD_BITS-1:0] lo_ff;
   logic [COORD_BITS:0]   hi_ff;
   logic [COORD_BITS-1:0] endp_ff;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   status_type            status_ff, status_c, res_status;
   logic                  avail_ff, avail_c, res_avail;
   logic                  finish, emit, slot_free, accept, full;
   act_type               act;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic                  rsp_avail_ff;
   logic [CNT_BITS-1:0]   rsp_count_ff;
   logic [COORD_BITS-1:0] rsp_left_ff;

   logic [COORD_BITS:0]   span_end;
   logic [COORD_BITS-1:0] start_vec [N];
   logic [COORD_BITS-1:0] end_vec [N];
   logic [COORD_BITS-1:0] start_next_vec [N];
   logic [N-1:0]          hit_vec, loeq_vec, hieq_vec, last_vec, drop_vec;
   logic [N-1:0]          sel_src, first_vec, above_vec;
   logic                  use_loeq, use_hieq;
   cell_ctl_type          ctl_vec [N];

   assign span_end  = {1'b0, req_position} + {1'b0, req_span_length};
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign full      = cnt_ff == CNT_BITS'(MAX_INTERVALS);

   assign sel_src   = (state_ff == ST_PRUNE) ? drop_vec : hit_vec;
   assign first_vec = sel_src & ~(sel_src - N'(1));
   assign above_vec = ~(sel_src ^ (sel_src - N'(1)));
   assign use_loeq  = |(first_vec & loeq_vec);
   assign use_hieq  = |(first_vec & hieq_vec);

   for (genvar g = 0; g < N; g++) begin : g_cell
      logic [COORD_BITS-1:0] left_start, left_end, right_start, right_end;
      logic                  right_drop, first_left;

      if (g == 0) begin : g_first
         assign left_start = '0;
         assign left_end   = '0;
         assign first_left = 1'b0;
      end else begin : g_inner_left
         assign left_start = start_vec[g-1];
         assign left_end   = end_vec[g-1];
         assign first_left = first_vec[g-1];
      end

      if (g == N - 1) begin : g_last
         assign right_start = '0;
         assign right_end   = '0;
         assign right_drop  = 1'b0;
      end else begin : g_inner_right
         assign right_start = start_vec[g+1];
         assign right_end   = end_vec[g+1];
         assign right_drop  = drop_vec[g+1];
      end

      assign ctl_vec[g].act        = act;
      assign ctl_vec[g].first      = first_vec[g];
      assign ctl_vec[g].above      = above_vec[g];
      assign ctl_vec[g].first_left = first_left;

      sfit_cell #(
         .INDEX         (g),
         .MAX_INTERVALS (MAX_INTERVALS),
         .COORD_BITS    (COORD_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl_vec[g]),
         .count       (cnt_ff),
         .smp_lo      (req_position),
         .smp_hi      (span_end),
         .smp_width   (req_span_length),
         .app_lo      (lo_ff),
         .app_hi      (hi_ff),
         .app_end     (endp_ff),
         .left_start  (left_start),
         .left_end    (left_end),
         .right_start (right_start),
         .right_end   (right_end),
         .right_drop  (right_drop),
         .cell_start  (start_vec[g]),
         .cell_end    (end_vec[g]),
         .start_next  (start_next_vec[g]),
         .hit         (hit_vec[g]),
         .lo_match    (loeq_vec[g]),
         .hi_match    (hieq_vec[g]),
         .last_below  (last_vec[g]),
         .drop        (drop_vec[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (op_type'(req_op) == OP_PRUNE) ? ST_PRUNE : ST_APPLY;
            end
         end
         ST_APPLY: begin
            state_in = slot_free ? ST_IDLE : ST_HOLD;
         end
         ST_PRUNE: begin
            if (!(|drop_vec)) begin
               state_in = slot_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      act       = ACT_NONE;
      cnt_in    = cnt_ff;
      status_c  = STATUS_OK;
      avail_c   = 1'b0;
      finish    = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               act = ACT_SAMPLE;
            end
         end
         ST_APPLY: begin
            finish = 1'b1;
            unique case (op_ff)
               OP_CLEAR: begin
                  cnt_in = '0;
               end
               OP_APPEND: begin
                  priority if ((endp_ff < lo_ff) || (|last_vec)) begin
                     status_c = STATUS_ORDER;
                  end else if (full) begin
                     status_c = STATUS_FULL;
                  end else begin
                     act    = ACT_APPEND;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                  end
               end
               OP_USE: begin
                  priority if (!(|hit_vec)) begin
                     status_c = STATUS_NOT_FOUND;
                  end else if (use_loeq && use_hieq) begin
                     act    = ACT_SHIFT_DOWN;
                     cnt_in = cnt_ff - CNT_BITS'(1);
                  end else if (use_loeq) begin
                     act = ACT_TRIM_LEFT;
                  end else if (use_hieq) begin
                     act = ACT_TRIM_RIGHT;
                  end else if (full) begin
                     status_c = STATUS_FULL;
                  end else begin
                     act    = ACT_SPLIT;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                  end
               end
               OP_QUERY: begin
                  avail_c = |hit_vec;
               end
               default: begin
               end
            endcase
         end
         ST_PRUNE: begin
            if (|drop_vec) begin
               act    = ACT_SHIFT_DOWN;
               cnt_in = cnt_ff - CNT_BITS'(1);
            end else begin
               finish = 1'b1;
            end
         end
         ST_HOLD: begin
            finish = 1'b1;
         end
      endcase
   end

   assign emit       = finish && slot_free;
   assign res_status = (state_ff == ST_HOLD) ? status_ff : status_c;
   assign res_avail  = (state_ff == ST_HOLD) ? avail_ff : avail_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_op);
         lo_ff   <= req_position;
         hi_ff   <= span_end;
         endp_ff <= req_end_position;
      end
      if (state_ff != ST_HOLD) begin
         status_ff <= status_c;
         avail_ff  <= avail_c;
      end
      if (emit) begin
         rsp_status_ff <= res_status;
         rsp_avail_ff  <= res_avail;
         rsp_count_ff  <= cnt_in;
         rsp_left_ff   <= (cnt_in != '0) ? start_next_vec[0] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_available      = rsp_avail_ff;
   assign rsp_interval_count = rsp_count_ff;
   assign rsp_leftmost_start = rsp_left_ff;

endmodule

`default_nettype wire

>>> sv/sfit_checker.sv
// Port-level checks for the sorted free interval table and their binding to the top level.
`default_nettype none

module sfit_checker #(
   parameter int MAX_INTERVALS = sfit_pkg::MAX_INTERVALS_DEF,
   parameter int COORD_BITS    = sfit_pkg::COORD_BITS_DEF,
   localparam int CNT_BITS     = $clog2(MAX_INTERVALS + 1)
) (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire [1:0]            rsp_status,
   input wire                  rsp_available,
   input wire [CNT_BITS-1:0]   rsp_interval_count,
   input wire [COORD_BITS-1:0] rsp_leftmost_start
);
   import sfit_pkg::*;

   // An accepted item is worked on alone, so the block cannot take another one next cycle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted in two consecutive cycles");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_interval_count <= CNT_BITS'(MAX_INTERVALS))
      else $error("interval count above table size");

   a_empty_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_interval_count == '0 |-> rsp_leftmost_start == '0)
      else $error("empty table with nonzero leftmost start");

   a_avail_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_available |-> rsp_status == STATUS_OK)
      else $error("available flag set on a failed item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_available) && $stable(rsp_interval_count) &&
         $stable(rsp_leftmost_start))
      else $error("result item changed while stalled");

endmodule

bind sorted_free_interval_table sfit_checker #(
   .MAX_INTERVALS (MAX_INTERVALS),
   .COORD_BITS    (COORD_BITS)
) u_sfit_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_available      (rsp_available),
   .rsp_interval_count (rsp_interval_count),
   .rsp_leftmost_start (rsp_leftmost_start)
);

`default_nettype wire

>>> test/sorted_free_interval_table_test.sv
// Self-checking testbench for the sorted free interval table with random handshake idling.
`timescale 1ns / 1ps

module sorted_free_interval_table_test;
   import sfit_pkg::*;

   localparam int CW       = COORD_BITS_DEF;
   localparam int MAX_N    = MAX_INTERVALS_DEF;
   localparam int CNT_W    = $clog2(MAX_N + 1);
   localparam longint COORD_TOP = (64'd1 << CW) - 1;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   typedef struct {
      status_type       status;
      logic             available;
      logic [CNT_W-1:0] count;
      logic [CW-1:0]    leftmost;
   } table_reply_type;

   class interval_table_mirror_type;
      logic [CW-1:0] starts [MAX_N];
      logic [CW-1:0] ends [MAX_N];
      int count = 0;
      int fails = 0;
      table_reply_type pending [$];

      function int find_holder(logic [CW-1:0] lo, logic [CW:0] hi);
         for (int i = 0; i < count; i++)
            if (starts[i] <= lo && hi <= {1'b0, ends[i]})
               return i;
         return -1;
      endfunction

      function table_reply_type apply_request(logic [2:0] op, logic [CW-1:0] pos,
                                              logic [CW-1:0] endp, logic [CW-1:0] len);
         table_reply_type r;
         logic [CW:0] hi;
         logic [CW-1:0] s, e;
         int i, wr;
         r.status = STATUS_OK;
         r.available = 1'b0;
         hi = {1'b0, pos} + {1'b0, len};
         case (op)
            OP_CLEAR: count = 0;
            OP_APPEND: begin
               if (endp < pos || (count > 0 && pos < ends[count-1])) begin
                  r.status = STATUS_ORDER;
               end else if (count >= MAX_N) begin
                  r.status = STATUS_FULL;
               end else begin
                  starts[count] = pos;
                  ends[count] = endp;
                  count++;
               end
            end
            OP_USE: begin
               i = find_holder(pos, hi);
               if (i < 0) begin
                  r.status = STATUS_NOT_FOUND;
               end else begin
                  s = starts[i];
                  e = ends[i];
                  if (pos == s && hi == {1'b0, e}) begin
                     for (int k = i; k + 1 < count; k++) begin
                        starts[k] = starts[k+1];
                        ends[k] = ends[k+1];
                     end
                     count--;
                  end else if (pos == s) begin
                     starts[i] = hi[CW-1:0];
                  end else if (hi == {1'b0, e}) begin
                     ends[i] = pos;
                  end else if (count >= MAX_N) begin
                     r.status = STATUS_FULL;
                  end else begin
                     for (int k = count; k > i + 1; k--) begin
                        starts[k] = starts[k-1];
                        ends[k] = ends[k-1];
                     end
                     starts[i+1] = hi[CW-1:0];
                     ends[i+1] = e;
                     ends[i] = pos;
                     count++;
                  end
               end
            end
            OP_QUERY: r.available = (find_holder(pos, hi) >= 0);
            OP_PRUNE: begin
               wr = 0;
               for (int rd = 0; rd < count; rd++) begin
                  if (ends[rd] - starts[rd] >= len) begin
                     starts[wr] = starts[rd];
                     ends[wr] = ends[rd];
                     wr++;
                  end
               end
               count = wr;
            end
            default: ;
         endcase
         r.count = CNT_W'(count);
         r.leftmost = (count > 0) ? starts[0] : '0;
         return r;
      endfunction

      function void note_request(logic [2:0] op, logic [CW-1:0] pos,
                                 logic [CW-1:0] endp, logic [CW-1:0] len);
         pending.push_back(apply_request(op, pos, endp, len));
      endfunction

      function void check_reply(logic [1:0] status, logic available,
                                logic [CNT_W-1:0] cnt, logic [CW-1:0] leftmost);
         table_reply_type want;
         if (pending.size() == 0) begin
            $error("result item arrived with no request outstanding");
            fails++;
            return;
         end
         want = pending.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            fails++;
         end
         if (available !== want.available) begin
            $error("available: expected %0d, got %0d", want.available, available);
            fails++;
         end
         if (cnt !== want.count) begin
            $error("interval_count: expected %0d, got %0d", want.count, cnt);
            fails++;
         end
         if (leftmost !== want.leftmost) begin
            $error("leftmost_start: expected %0h, got %0h", want.leftmost, leftmost);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_op = '0;
   logic [CW-1:0] req_position = '0;
   logic [CW-1:0] req_end_position = '0;
   logic [CW-1:0] req_span_length = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic rsp_available;
   logic [CNT_W-1:0] rsp_interval_count;
   logic [CW-1:0] rsp_leftmost_start;

   interval_table_mirror_type mirror;
   int items_sent = 0;
   int cycle_count = 0;
   bit send_steady = 1'b0;
   bit rsp_steady = 1'b0;
   logic [CW-1:0] cursor = '0;

   sorted_free_interval_table u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_position(req_position),
      .req_end_position(req_end_position),
      .req_span_length(req_span_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_available(rsp_available),
      .rsp_interval_count(rsp_interval_count),
      .rsp_leftmost_start(rsp_leftmost_start)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [CW-1:0] clamp_add(longint a, longint b);
      longint sum;
      sum = a + b;
      return (sum > COORD_TOP) ? COORD_TOP[CW-1:0] : sum[CW-1:0];
   endfunction

   // Picks a span aimed at a stored interval: whole, trimmed, split, zero length or overrun.
   function automatic void pick_span(output logic [CW-1:0] pos, output logic [CW-1:0] len);
      int i;
      logic [CW-1:0] s, e, w, off;
      if (mirror.count == 0) begin
         pos = CW'($urandom_range(0, 200));
         len = CW'($urandom_range(0, 8));
         return;
      end
      i = $urandom_range(0, mirror.count - 1);
      s = mirror.starts[i];
      e = mirror.ends[i];
      w = e - s;
      off = CW'($urandom_range(0, w));
      case ($urandom_range(0, 6))
         0: begin pos = s; len = w; end
         1: begin pos = s; len = CW'($urandom_range(0, w)); end
         2: begin pos = s + off; len = w - off; end
         3, 4: begin pos = s + off; len = CW'($urandom_range(0, w - off)); end
         5: begin pos = s + off; len = '0; end
         default: begin pos = s + off; len = w - off + CW'($urandom_range(1, 4)); end
      endcase
   endfunction

   task automatic send_item(input logic [2:0] op, input logic [CW-1:0] pos,
                            input logic [CW-1:0] endp, input logic [CW-1:0] len);
      int idle;
      idle = pick_gap(send_steady);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_position <= pos;
      req_end_position <= endp;
      req_span_length <= len;
      do @(posedge clock); while (!req_ready);
      mirror.note_request(op, pos, endp, len);
      items_sent++;
   endtask

   initial begin
      int idle;
      while (reset) @(posedge clock);
      forever begin
         idle = pick_gap(rsp_steady);
         if (idle > 0) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         mirror.check_reply(rsp_status, rsp_available, rsp_interval_count,
                            rsp_leftmost_start);
         if ($urandom_range(0, 39) == 0)
            rsp_steady = !rsp_steady;
      end
   end

   initial begin
      bit fill;
      int round_len, r;
      logic [2:0] op;
      logic [CW-1:0] pos, endp, len, lo_min;
      mirror = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_QUERY, 0, 0, 0);
      send_item(OP_USE, 5, 0, 3);
      send_item(OP_APPEND, 10, 5, 0);
      send_item(OP_APPEND, 0, 0, 0);
      send_item(OP_APPEND, 0, 10, 0);
      send_item(OP_APPEND, 5, 20, 0);
      send_item(OP_APPEND, 10, 30, 0);
      send_item(OP_USE, 0, 0, 0);
      send_item(OP_USE, 3, 0, 0);
      send_item(OP_USE, 0, 0, 3);
      send_item(OP_USE, 3, 0, 2);
      send_item(OP_USE, 8, 0, 2);
      send_item(OP_USE, 12, 0, 4);
      send_item(OP_QUERY, 16, 0, 14);
      send_item(OP_QUERY, 16, 0, 15);
      send_item(OP_USE, 100, 0, 1);
      send_item(OP_APPEND, 24'hFFFFF0, 24'hFFFFFF, 0);
      send_item(OP_QUERY, 24'hFFFFFF, 0, 24'hFFFFFF);
      send_item(OP_QUERY, 24'hFFFFF0, 0, 24'h00000F);
      send_item(OP_PRUNE, 0, 0, 0);
      send_item(OP_PRUNE, 0, 0, 3);
      send_item(OP_PRUNE, 0, 0, 24'hFFFFFF);
      send_item(OP_SPARE_FIRST, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_item(OP_SPARE_LAST, CW'($urandom()), CW'($urandom()), CW'($urandom()));
      send_item(OP_CLEAR, 0, 0, 0);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         fill = ($urandom_range(0, 3) == 0);
         send_steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            cursor = clamp_add(COORD_TOP - 3000, $urandom_range(0, 3000));
         else
            cursor = CW'($urandom_range(0, 24'hF00000));
         if (fill || $urandom_range(0, 3) != 0)
            send_item(OP_CLEAR, CW'($urandom()), CW'($urandom()), CW'($urandom()));
         round_len = fill ? 140 : $urandom_range(15, 60);
         repeat (round_len) begin
            r = $urandom_range(0, 99);
            lo_min = (mirror.count > 0) ? mirror.ends[mirror.count - 1] : cursor;
            if (fill)
               op = (r < 65) ? OP_APPEND : (r < 88) ? OP_USE : (r < 95) ? OP_QUERY : OP_PRUNE;
            else
               op = (r < 30) ? OP_APPEND : (r < 60) ? OP_USE : (r < 80) ? OP_QUERY :
                    (r < 85) ? OP_PRUNE : OP_SPARE_LAST;
            pos = '0;
            endp = '0;
            len = '0;
            case (op)
               OP_APPEND: begin
                  r = $urandom_range(0, 99);
                  if (r < 8 && lo_min > 0) begin
                     pos = CW'($urandom_range(0, lo_min - 1));
                     endp = clamp_add(pos, $urandom_range(0, 40));
                  end else if (r < 12) begin
                     pos = clamp_add(lo_min, $urandom_range(1, 50));
                     endp = (pos > 0) ? pos - CW'($urandom_range(1, pos)) : '0;
                  end else begin
                     pos = clamp_add(lo_min, (r < 40) ? 0 :
                                             (r < 97) ? $urandom_range(1, 16) :
                                                        $urandom_range(1000, 100000));
                     if ($urandom_range(0, 9) == 0)
                        endp = pos;
                     else if ($urandom_range(0, 19) == 0)
                        endp = clamp_add(pos, $urandom_range(1000, 1000000));
                     else
                        endp = clamp_add(pos, $urandom_range(1, 40));
                  end
                  len = CW'($urandom());
               end
               OP_USE, OP_QUERY: begin
                  pick_span(pos, len);
                  endp = CW'($urandom());
               end
               OP_PRUNE: begin
                  len = ($urandom_range(0, 3) == 0) ? CW'($urandom())
                                                    : CW'($urandom_range(0, 24));
                  pos = CW'($urandom());
               end
               default: begin
                  op = 3'($urandom_range(0, 7));
                  pos = CW'($urandom());
                  endp = CW'($urandom());
                  len = CW'($urandom());
               end
            endcase
            send_item(op, pos, endp, len);
         end
      end

      req_valid <= 1'b0;
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.fails == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
